@@ hw/rtl/vad_pkg.sv @@
`default_nettype none

package vad_pkg;

  localparam int unsigned VAD_TABLE_DEPTH = 256;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned VIDX_W          = 8;
  localparam int unsigned CFG_IDX_W       = 8;
  localparam int unsigned CFG_DATA_W      = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USE_NORMALS   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_USE_TEXCOORDS = CFG_IDX_W'(1);

  localparam logic [WORD_W-1:0] ABS_MASK = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] EXP_INF  = 32'h7F80_0000;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t norm_x;
    word_t norm_y;
    word_t norm_z;
    word_t tex_u;
    word_t tex_v;
  } vad_entry_t;

  typedef struct packed {
    logic  start_of_mesh;
    word_t pos_x;
    word_t pos_y;
    word_t pos_z;
    word_t norm_x;
    word_t norm_y;
    word_t norm_z;
    word_t tex_u;
    word_t tex_v;
  } vad_in_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic              is_new;
    logic              table_full;
  } vad_out_t;

  typedef struct packed {
    logic use_normals;
    logic use_texcoords;
  } vad_match_ctl_t;

  // IEEE single equality on bit patterns: signed zeros equal, NaN never equal
  function automatic logic ieee_eq(input word_t a, input word_t b);
    logic a_nan;
    logic b_nan;
    logic both_zero;
    a_nan     = (a & ABS_MASK) > EXP_INF;
    b_nan     = (b & ABS_MASK) > EXP_INF;
    both_zero = ((a | b) & ABS_MASK) == '0;
    return !a_nan && !b_nan && (both_zero || (a == b));
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/vad_entry_ram.sv @@
`default_nettype none

module vad_entry_ram
  import vad_pkg::*;
#(
  parameter int unsigned DEPTH = VAD_TABLE_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire vad_entry_t    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output vad_entry_t         rd_data
);

  vad_entry_t mem [DEPTH];
  vad_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/vad_cmp.sv @@
`default_nettype none

module vad_cmp
  import vad_pkg::*;
(
  input  wire vad_entry_t     entry,
  input  wire vad_entry_t     vertex,
  input  wire vad_match_ctl_t ctl,
  output logic                match
);

  logic pos_eq;
  logic norm_eq;
  logic tex_eq;

  always_comb begin
    pos_eq  = ieee_eq(entry.pos_x, vertex.pos_x) &&
              ieee_eq(entry.pos_y, vertex.pos_y) &&
              ieee_eq(entry.pos_z, vertex.pos_z);
    norm_eq = ieee_eq(entry.norm_x, vertex.norm_x) &&
              ieee_eq(entry.norm_y, vertex.norm_y) &&
              ieee_eq(entry.norm_z, vertex.norm_z);
    tex_eq  = ieee_eq(entry.tex_u, vertex.tex_u) &&
              ieee_eq(entry.tex_v, vertex.tex_v);
    match   = pos_eq && (!ctl.use_normals || norm_eq) && (!ctl.use_texcoords || tex_eq);
  end

endmodule

`default_nettype wire

@@ hw/rtl/vertex_attribute_deduplicator.sv @@
// Vertex deduplicator: maps each incoming mesh vertex to an index in a table
// of unique vertices, appending it when no stored entry matches.
// Input channel (in_valid/in_stall/in_data): one vertex request, with
// start_of_mesh emptying the table before that vertex is handled.
// Result channel (out_valid/out_stall/out_data): one result per request,
// in request order, held in an output register.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): bit 0 of the
// data sets use_normals (index 0) or use_texcoords (index 1); other indexes
// are dropped. cfg_ready is always high. Write only while the block is idle.
// A hit is reported once the matching entry has been read and compared, a
// miss or a full table once every stored entry has been checked.
// A request occupies the block until its search ends: one table entry is read per
// cycle from the single-read-port entry memory and checked by one compare
// unit, so a new vertex is taken only once the previous search has ended.
// in_stall is high while a search runs; a new request is taken while the
// previous result still waits on a stalled receiver, but its search cannot
// finish until that result has left.
// Reset clears the entry count, the config registers and out_valid; memory
// contents are left as they are.

`default_nettype none

module vertex_attribute_deduplicator
  import vad_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = VAD_TABLE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire vad_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output vad_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  vad_out_t         out_data_r, out_data_nxt;
  vad_entry_t       vtx_r;
  vad_match_ctl_t   ctl_r;

  logic       in_acc;
  logic       out_free;
  logic       match;
  logic       rd_en;
  logic       wr_en;
  vad_entry_t rd_data;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config registers, only bit 0 of the data is kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_USE_NORMALS) begin
        ctl_r.use_normals <= cfg_data[0];
      end else if (cfg_index == REG_USE_TEXCOORDS) begin
        ctl_r.use_texcoords <= cfg_data[0];
      end
    end
  end

  // latch the vertex under search
  always_ff @(posedge clk) begin
    if (in_acc) begin
      vtx_r.pos_x  <= in_data.pos_x;
      vtx_r.pos_y  <= in_data.pos_y;
      vtx_r.pos_z  <= in_data.pos_z;
      vtx_r.norm_x <= in_data.norm_x;
      vtx_r.norm_y <= in_data.norm_y;
      vtx_r.norm_z <= in_data.norm_z;
      vtx_r.tex_u  <= in_data.tex_u;
      vtx_r.tex_v  <= in_data.tex_v;
    end
  end

  vad_entry_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (vtx_r),
    .rd_en   (rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  vad_cmp u_cmp (
    .entry  (rd_data),
    .vertex (vtx_r),
    .ctl    (ctl_r),
    .match  (match)
  );

  // Search sequencer: issue one read per cycle and check the entry read in
  // the previous cycle; finish on the first hit or once every entry is done.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt   = ST_SCAN;
          idx_nxt     = '0;
          cmp_vld_nxt = 1'b0;
          if (in_data.start_of_mesh) begin
            count_nxt = '0;
          end
        end
      end
      ST_SCAN: begin
        if (cmp_vld_r && match) begin
          // hit: hold until the output register is free
          if (out_free) begin
            out_valid_nxt             = 1'b1;
            out_data_nxt.vertex_index = VIDX_W'(cmp_idx_r);
            out_data_nxt.is_new       = 1'b0;
            out_data_nxt.table_full   = 1'b0;
            state_nxt                 = ST_IDLE;
          end
        end else if (idx_r == count_r) begin
          // miss after the whole table
          if (out_free) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
            if (count_r == CNT_FULL) begin
              out_data_nxt.vertex_index = '0;
              out_data_nxt.is_new       = 1'b0;
              out_data_nxt.table_full   = 1'b1;
            end else begin
              wr_en                     = 1'b1;
              out_data_nxt.vertex_index = VIDX_W'(count_r);
              out_data_nxt.is_new       = 1'b1;
              out_data_nxt.table_full   = 1'b0;
              count_nxt                 = count_r + CNT_W'(1);
            end
          end
        end else begin
          rd_en       = 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cmp_idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/vad_checker.sv @@
`default_nettype none

module vad_checker
  import vad_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire vad_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a result is never both new and full
  a_new_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_new && out_data.table_full))
    else $error("is_new and table_full both set");

  // a full-table result carries index zero
  a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> out_data.vertex_index == '0)
    else $error("full result with nonzero index");

  // the block is busy in the cycle after a request is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken without busy cycle");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vertex_attribute_deduplicator vad_checker u_vad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
